// ----- rtl/dssc_pkg.sv -----
// ============================================================================
// dssc_pkg: shared types and constants of the seven-segment command unit
// Digit codes, register addresses, divider constants and the segment table.
// ============================================================================
package dssc_pkg;

  // Saturation limit of the displayed value.
  localparam int unsigned VALUE_W = 14;
  localparam logic [VALUE_W-1:0] VALUE_MAX = 14'd9999;

  // Digit code that selects an unlit digit.
  localparam logic [3:0] DIGIT_BLANK = 4'd10;

  // Point mode codes.
  localparam logic [1:0] PM_PLAIN   = 2'd0;
  localparam logic [1:0] PM_POINT_A = 2'd1;
  localparam logic [1:0] PM_POINT_B = 2'd2;
  localparam logic [1:0] PM_SKIP    = 2'd3;

  // Digit register addresses of the display controller.
  localparam logic [3:0] ADDR_THOUSANDS = 4'h8;
  localparam logic [3:0] ADDR_HUNDREDS  = 4'h9;
  localparam logic [3:0] ADDR_TENS      = 4'hA;
  localparam logic [3:0] ADDR_UNITS     = 4'hB;

  localparam logic [7:0] DP_BIT = 8'h80;

  // Reciprocal constants for division by 1000, 100 and 10; each is exact
  // over the range of its dividend (below 10000, 1000 and 100).
  localparam logic [13:0] RECIP_1000 = 14'd8389;  // 2^23 / 1000, rounded up
  localparam logic [5:0]  RECIP_100  = 6'd41;     // 2^12 / 100, rounded up
  localparam logic [7:0]  RECIP_10   = 8'd205;    // 2^11 / 10, rounded up

  // Default depth of the queue between classifier and sequencer.
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  // One classified value: four digit codes and the point mode.
  typedef struct packed {
    logic [3:0] thousands;
    logic [3:0] hundreds;
    logic [3:0] tens;
    logic [3:0] units;
    logic [1:0] point_mode;
  } entry_t;

  // Active-high segment pattern, bit 0 = a through bit 6 = g.
  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    logic [7:0] seg;
    begin
      unique case (digit)
        4'd0:    seg = 8'h3f;
        4'd1:    seg = 8'h06;
        4'd2:    seg = 8'h5b;
        4'd3:    seg = 8'h4f;
        4'd4:    seg = 8'h66;
        4'd5:    seg = 8'h6d;
        4'd6:    seg = 8'h7d;
        4'd7:    seg = 8'h07;
        4'd8:    seg = 8'h7f;
        4'd9:    seg = 8'h6f;
        default: seg = 8'h00;
      endcase
      return seg;
    end
  endfunction

endpackage

// ----- rtl/dssc_in_if.sv -----
// ============================================================================
// dssc_in_if: value channel
// Valid/ready channel that carries one value and its point mode.
// ============================================================================
interface dssc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] value;
  logic [1:0]  point_mode;

  modport source (output valid, output value, output point_mode, input ready);
  modport sink   (input valid, input value, input point_mode, output ready);
endinterface

// ----- rtl/dssc_out_if.sv -----
// ============================================================================
// dssc_out_if: command channel
// Valid/ready channel that carries one display command word.
// ============================================================================
interface dssc_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] command_word;
  logic        last;

  modport source (output valid, output command_word, output last, input ready);
  modport sink   (input valid, input command_word, input last, output ready);
endinterface

// ----- rtl/decimal_seven_segment_commands_unit.sv -----
// ============================================================================
// decimal_seven_segment_commands_unit: four-digit seven-segment commands
// Turns a binary value into display-controller command words, one per digit.
// ============================================================================
// Usage: a value and a point mode enter on the req channel; each accepted
// transfer produces four command transfers on the cmd channel (thousands,
// hundreds, tens, units), or three when the point mode skips the tens
// register. The units command carries last. Values above 9999 show 9999.
// The first command of a value passes the five splitter stages, the queue
// and the output stage in turn. Throughput: the sequencer issues one
// command word per cycle while the receiver is ready, four words per value
// (three with the tens register skipped); the splitter takes a new value
// every cycle until its pipeline and the queue are full.
// Reset clears the pipeline valid bits, the queue and the output stage;
// no command is pending afterwards. When the receiver holds ready low, the
// output stage keeps its word, the sequencer waits, the queue fills, and
// then req.ready falls.
// ============================================================================
module decimal_seven_segment_commands_unit #(
  parameter int unsigned QUEUE_DEPTH = dssc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  dssc_in_if.sink    req,
  dssc_out_if.source cmd
);
  import dssc_pkg::*;

  // Classified values leave the splitter pipeline here.
  logic   push;
  entry_t push_entry;
  logic   queue_not_full;

  // Queue head as seen by the sequencer.
  logic   head_valid;
  entry_t head;
  logic   pop;

  // Splitting and blanking: five stages, one value per cycle while the queue has room.
  dssc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .push        (push),
    .push_entry  (push_entry),
    .queue_ready (queue_not_full)
  );

  // The queue lets the splitter run ahead while commands drain slowly.
  dssc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .not_full   (queue_not_full),
    .not_empty  (head_valid),
    .pop        (pop),
    .head       (head)
  );

  // The sequencer removes an entry when its units command is issued.
  dssc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .entry_valid (head_valid),
    .entry       (head),
    .pop         (pop),
    .cmd         (cmd)
  );

endmodule

// ----- rtl/dssc_front.sv -----
// ============================================================================
// dssc_front: value splitter and classifier
// Five-stage pipeline that saturates the value, splits it into decimal
// digits by reciprocal multiplication and applies leading-zero blanking.
// ============================================================================
module dssc_front (
  input  logic                  clk,
  input  logic                  rst,
  dssc_in_if.sink               req,
  output logic                  push,
  output dssc_pkg::entry_t      push_entry,
  input  logic                  queue_ready
);
  import dssc_pkg::*;

  // Stage valid bits.
  logic [4:0] stage_valid;
  logic       advance;

  // Stage 1
  logic [VALUE_W-1:0] s1_value;
  logic [3:0]         s1_q3;
  logic [1:0]         s1_pm;
  // Stage 2
  logic [9:0]         s2_r3;
  logic [3:0]         s2_q3;
  logic [1:0]         s2_pm;
  // Stage 3
  logic [9:0]         s3_r3;
  logic [3:0]         s3_q3;
  logic [3:0]         s3_q2;
  logic [1:0]         s3_pm;
  // Stage 4
  logic [6:0]         s4_r2;
  logic [3:0]         s4_q3;
  logic [3:0]         s4_q2;
  logic [1:0]         s4_pm;
  // Stage 5 holds the classified entry.
  entry_t             s5_entry;

  logic [VALUE_W-1:0] sat_value;
  logic [27:0]        prod3;
  logic [13:0]        rem3_full;
  logic [15:0]        prod2;
  logic [9:0]         rem2_full;
  logic [14:0]        prod1;
  logic [3:0]         q1;
  logic [6:0]         rem1_full;
  logic [3:0]         d3;
  logic [3:0]         d2;
  logic [3:0]         d1;

  // The whole pipeline moves together; it halts only when the last stage
  // holds an entry that the queue cannot take. No transfer is taken in reset.
  assign advance   = !stage_valid[4] || queue_ready;
  assign req.ready = advance && !rst;

  assign sat_value = (req.value > 16'(VALUE_MAX)) ? VALUE_MAX : req.value[VALUE_W-1:0];
  assign prod3     = 28'(sat_value) * 28'(RECIP_1000);
  assign rem3_full = s1_value - 14'(s1_q3) * 14'd1000;
  assign prod2     = 16'(s2_r3) * 16'(RECIP_100);
  assign rem2_full = s3_r3 - 10'(s3_q2) * 10'd100;
  assign prod1     = 15'(s4_r2) * 15'(RECIP_10);
  assign q1        = prod1[14:11];
  assign rem1_full = s4_r2 - 7'(q1) * 7'd10;

  // Leading-zero blanking; the tens place is blanked only without a point.
  always_comb begin
    d3 = s4_q3;
    d2 = s4_q2;
    d1 = q1;
    if (s4_q3 == 4'd0) begin
      d3 = DIGIT_BLANK;
      if (s4_q2 == 4'd0) begin
        d2 = DIGIT_BLANK;
        if (q1 == 4'd0 && s4_pm == PM_PLAIN) begin
          d1 = DIGIT_BLANK;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else if (advance) begin
      stage_valid <= {stage_valid[3:0], req.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_value <= sat_value;
      s1_q3    <= prod3[26:23];
      s1_pm    <= req.point_mode;

      s2_r3    <= rem3_full[9:0];
      s2_q3    <= s1_q3;
      s2_pm    <= s1_pm;

      s3_r3    <= s2_r3;
      s3_q3    <= s2_q3;
      s3_q2    <= prod2[15:12];
      s3_pm    <= s2_pm;

      s4_r2    <= rem2_full[6:0];
      s4_q3    <= s3_q3;
      s4_q2    <= s3_q2;
      s4_pm    <= s3_pm;

      s5_entry.thousands  <= d3;
      s5_entry.hundreds   <= d2;
      s5_entry.tens       <= d1;
      s5_entry.units      <= rem1_full[3:0];
      s5_entry.point_mode <= s4_pm;
    end
  end

  assign push       = stage_valid[4];
  assign push_entry = s5_entry;

endmodule

// ----- rtl/dssc_queue.sv -----
// ============================================================================
// dssc_queue: entry queue
// Small first-in first-out queue of classified values between the
// classifier and the command sequencer.
// ============================================================================
module dssc_queue #(
  parameter int unsigned DEPTH = dssc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  dssc_pkg::entry_t push_entry,
  output logic             not_full,
  output logic             not_empty,
  input  logic             pop,
  output dssc_pkg::entry_t head
);
  import dssc_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t           entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign not_full  = (count != CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

endmodule

// ----- rtl/dssc_back.sv -----
// ============================================================================
// dssc_back: command sequencer
// Walks the digit places of the queue head and issues one command word per
// cycle, while the receiver is ready, into a registered output stage.
// ============================================================================
module dssc_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             entry_valid,
  input  dssc_pkg::entry_t entry,
  output logic             pop,
  dssc_out_if.source       cmd
);
  import dssc_pkg::*;

  localparam logic [1:0] POS_THOUSANDS = 2'd0;
  localparam logic [1:0] POS_HUNDREDS  = 2'd1;
  localparam logic [1:0] POS_TENS      = 2'd2;
  localparam logic [1:0] POS_UNITS     = 2'd3;

  logic [1:0]  pos;
  logic [1:0]  pos_next;
  logic        load;
  logic [11:0] word;
  logic        word_last;
  logic        out_valid;
  logic [11:0] out_word;
  logic        out_last;

  assign load = entry_valid && (!out_valid || cmd.ready);
  assign pop  = load && (pos == POS_UNITS);

  always_comb begin
    word_last = 1'b0;
    pos_next  = pos + 1'b1;
    unique case (pos)
      POS_THOUSANDS: word = {ADDR_THOUSANDS, seg_of(entry.thousands)};
      POS_HUNDREDS: begin
        word = {ADDR_HUNDREDS, seg_of(entry.hundreds)};
        if (entry.point_mode == PM_SKIP) begin
          pos_next = POS_UNITS;
        end
      end
      POS_TENS: begin
        word = {ADDR_TENS, seg_of(entry.tens)};
        if (entry.point_mode != PM_PLAIN) begin
          word[7:0] = word[7:0] | DP_BIT;
        end
      end
      POS_UNITS: begin
        word      = {ADDR_UNITS, seg_of(entry.units)};
        word_last = 1'b1;
      end
      default: word = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= POS_THOUSANDS;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        pos       <= pos_next;
        out_valid <= 1'b1;
      end else if (cmd.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word <= word;
      out_last <= word_last;
    end
  end

  assign cmd.valid        = out_valid;
  assign cmd.command_word = out_word;
  assign cmd.last         = out_last;

endmodule

// ----- sim/tb_decimal_seven_segment_commands_unit.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_decimal_seven_segment_commands_unit: self-checking bench of the unit
// Sends values with every point mode and compares each command transfer with
// the commands that the bench works out itself. The sender idles in bursts
// and the receiver stalls on a pattern of its own.
// ============================================================================
module tb_decimal_seven_segment_commands_unit;
  import dssc_pkg::*;

  // The clock toggles every 2 ns, so one cycle lasts 4 ns.
  localparam int unsigned RESET_CYCLES = 9;
  // The drain at the end waits a good deal longer than the first command of
  // a value takes to show up after the value is accepted.
  localparam int unsigned DRAIN_CYCLES = 24;
  // The quiet stretches of a correct run are receiver stalls and sender
  // gaps; this limit is many times longer than either.
  localparam int unsigned IDLE_LIMIT   = 1000;

  // Active-high segment patterns of the digits 0 to 9 (bit 0 = a).
  localparam logic [7:0] DIGIT_SEGMENTS [0:9] = '{
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
  };

  // Receiver behaviors that follow one another at random.
  typedef enum logic [1:0] {
    RX_ALWAYS,    // ready every cycle
    RX_COIN,      // ready half of the time
    RX_MOSTLY,    // rare stalls
    RX_PERIODIC   // long stall, then one cycle of ready
  } rx_behavior_t;

  // One command as it leaves the unit.
  typedef struct packed {
    logic [11:0] command_word;
    logic        last;
  } command_t;

  logic clk;
  logic rst;

  dssc_in_if  req_if ();
  dssc_out_if cmd_if ();

  decimal_seven_segment_commands_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .cmd (cmd_if)
  );

  // Commands that have been worked out but not yet seen, oldest first.
  command_t    pending_commands [$];
  int unsigned mismatch_count;
  int unsigned burst_left;
  bit          sender_gaps;
  int unsigned idle_cycles;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Command prediction
  // --------------------------------------------------------------------------

  // Segment pattern of one digit code; the blank code lights nothing.
  function automatic logic [7:0] segments_of(input int unsigned digit);
    if (digit < 10) return DIGIT_SEGMENTS[digit];
    return 8'h00;
  endfunction

  function automatic void queue_command(input logic [3:0] addr, input logic [7:0] seg,
                                        input logic last);
    command_t c;
    c.command_word = {addr, seg};
    c.last         = last;
    pending_commands.push_back(c);
  endfunction

  // Works out the commands of one accepted value and queues them in the
  // order the unit must send them.
  function automatic void predict_commands(input logic [15:0] value,
                                           input logic [1:0] point_mode);
    int unsigned shown;
    int unsigned units, tens, hundreds, thousands;
    logic [7:0]  tens_seg;
    // Anything past four digits is shown as the largest four-digit number.
    shown     = (value > VALUE_MAX) ? VALUE_MAX : value;
    units     = shown % 10;
    tens      = (shown / 10) % 10;
    hundreds  = (shown / 100) % 10;
    thousands = shown / 1000;
    // Leading zeros go dark. The tens place only goes dark when no point
    // is asked for, so a point mode keeps "0." visible on small values.
    if (thousands == 0) begin
      if (hundreds == 0) begin
        if (tens == 0 && point_mode == PM_PLAIN) tens = DIGIT_BLANK;
        hundreds = DIGIT_BLANK;
      end
      thousands = DIGIT_BLANK;
    end
    queue_command(ADDR_THOUSANDS, segments_of(thousands), 1'b0);
    queue_command(ADDR_HUNDREDS, segments_of(hundreds), 1'b0);
    tens_seg = segments_of(tens);
    case (point_mode)
      PM_PLAIN:               queue_command(ADDR_TENS, tens_seg, 1'b0);
      PM_POINT_A, PM_POINT_B: queue_command(ADDR_TENS, tens_seg | DP_BIT, 1'b0);
      default: ;  // the tens register is left alone
    endcase
    queue_command(ADDR_UNITS, segments_of(units), 1'b1);
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [11:0] got,
                                 input logic [11:0] want);
    $display("%0t ns: mismatch in %s: got 0x%03h, expected 0x%03h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Every command transfer is held against the oldest pending command.
  always @(posedge clk) begin
    command_t want;
    if (!rst && cmd_if.valid && cmd_if.ready) begin
      if (pending_commands.size() == 0) begin
        report_mismatch("unexpected command", cmd_if.command_word, 12'h000);
      end else begin
        want = pending_commands.pop_front();
        if (cmd_if.command_word !== want.command_word)
          report_mismatch("command_word", cmd_if.command_word, want.command_word);
        if (cmd_if.last !== want.last)
          report_mismatch("last", {11'd0, cmd_if.last}, {11'd0, want.last});
      end
    end
  end

  // Watchdog: a run in which no transfer happens for too long has hung.
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (cmd_if.valid && cmd_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: ready follows a behavior that changes after a random stretch.
  // --------------------------------------------------------------------------
  initial begin
    rx_behavior_t behavior;
    int unsigned  stretch;
    cmd_if.ready = 1'b0;
    forever begin
      behavior = rx_behavior_t'($urandom_range(0, 3));
      stretch  = $urandom_range(8, 60);
      for (int unsigned n = 0; n < stretch; n++) begin
        @(negedge clk);
        case (behavior)
          RX_ALWAYS:   cmd_if.ready = 1'b1;
          RX_COIN:     cmd_if.ready = 1'($urandom_range(0, 1));
          RX_MOSTLY:   cmd_if.ready = ($urandom_range(0, 7) != 0);
          RX_PERIODIC: cmd_if.ready = (n % 12 == 11);
          default:     cmd_if.ready = 1'b1;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------

  // Offers one value until it is accepted, then queues its commands. When
  // the current burst runs out, valid drops for a random gap; otherwise it
  // stays high so the next value follows at once.
  task automatic send_value(input logic [15:0] value, input logic [1:0] point_mode);
    int unsigned gap;
    @(negedge clk);
    req_if.valid      = 1'b1;
    req_if.value      = value;
    req_if.point_mode = point_mode;
    do @(posedge clk); while (!req_if.ready);
    predict_commands(value, point_mode);
    if (sender_gaps) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        @(negedge clk);
        req_if.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
        burst_left = $urandom_range(1, 8);
      end else begin
        burst_left--;
      end
    end
  endtask

  // A value drawn mostly from inside the display range, with its magnitude
  // spread so that every blanking depth shows up, and some overflow.
  function automatic logic [15:0] random_value();
    case ($urandom_range(0, 9))
      0:       return 16'($urandom_range(0, 9));
      1:       return 16'($urandom_range(10, 99));
      2:       return 16'($urandom_range(100, 999));
      3, 4, 5: return 16'($urandom_range(1000, 9999));
      6:       return 16'($urandom_range(9990, 10010));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Edges of the value range and of the blanking, with every point mode.
  task automatic test_directed();
    logic [1:0] modes [4] = '{PM_PLAIN, PM_POINT_A, PM_POINT_B, PM_SKIP};
    // Zero: only units lit with no point, "0." on the tens with a point.
    foreach (modes[i]) send_value(16'd0, modes[i]);
    // A single digit with the tens skipped: tens stays unblanked but unused.
    send_value(16'd7, PM_SKIP);
    send_value(16'd9, PM_PLAIN);
    send_value(16'd10, PM_PLAIN);
    send_value(16'd99, PM_POINT_A);
    send_value(16'd100, PM_PLAIN);
    send_value(16'd999, PM_POINT_B);
    send_value(16'd1000, PM_PLAIN);
    // Inner zeros must stay lit once a higher digit is shown.
    send_value(16'd1001, PM_PLAIN);
    send_value(16'd1234, PM_POINT_A);
    send_value(16'd5678, PM_SKIP);
    send_value(16'd9999, PM_PLAIN);
    // Above range every value shows as 9999.
    send_value(16'd10000, PM_POINT_B);
    send_value(16'hffff, PM_PLAIN);
    send_value(16'h8000, PM_SKIP);
    send_value(16'h5555, PM_POINT_A);
    send_value(16'haaaa, PM_PLAIN);
  endtask

  // Random values and modes while the sender idles in bursts.
  task automatic test_random_bursts();
    sender_gaps = 1'b1;
    burst_left  = $urandom_range(1, 8);
    for (int i = 0; i < 60; i++) send_value(random_value(), 2'($urandom_range(0, 3)));
  endtask

  // Back-to-back values with no sender gaps, so the queue fills and
  // req.ready has to fall.
  task automatic test_streaming();
    sender_gaps = 1'b0;
    for (int i = 0; i < 30; i++) send_value(random_value(), 2'($urandom_range(0, 3)));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst                 = 1'b1;
    req_if.valid        = 1'b0;
    req_if.value        = '0;
    req_if.point_mode   = PM_PLAIN;
    mismatch_count      = 0;
    idle_cycles         = 0;
    sender_gaps         = 1'b0;
    burst_left          = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random_bursts();
    test_streaming();

    @(negedge clk);
    req_if.valid = 1'b0;
    // Let every pending command arrive; the watchdog guards this wait.
    while (pending_commands.size() != 0) @(posedge clk);
    // Any stray command after the last one would show up within this time.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/dssc_pkg.sv
rtl/dssc_in_if.sv
rtl/dssc_out_if.sv
rtl/dssc_front.sv
rtl/dssc_queue.sv
rtl/dssc_back.sv
rtl/decimal_seven_segment_commands_unit.sv
sim/tb_decimal_seven_segment_commands_unit.sv
